### rtl/nht_pkg.sv
`timescale 1ns / 1ps
// nht_pkg: shared types and constants of the neighbor heard table
// used by nht_merge and neighbor_heard_table; no dependencies
package nht_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam logic [31:0] BROADCAST_ID       = 32'hFFFF_FFFF;
  localparam logic [31:0] CLOCK_SANE_MIN_RST = 32'd1600000000;

  // request kinds (in_tuser)
  localparam logic [1:0] REQ_SYNC  = 2'd0;
  localparam logic [1:0] REQ_HEARD = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  // result status (out_tuser)
  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_FILTERED = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_OWN_ID       = 2'd0;
  localparam logic [1:0] CFG_OWN_ID_VALID = 2'd1;
  localparam logic [1:0] CFG_SANE_MIN     = 2'd2;

  // one table entry, seen_time in the lowest bits
  typedef struct packed {
    logic              relay;
    logic              hops_valid;
    logic [7:0]        hops;
    logic signed [10:0] snr_q;
    logic [31:0]       seen_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one request, node_id in the lowest bits
  typedef struct packed {
    logic [1:0]        req_type;
    logic [2:0]        hop_left;
    logic [2:0]        hop_init;
    logic [7:0]        hop_dist;
    logic              has_hops;
    logic              via_relay;
    logic signed [10:0] snr_q;
    logic [31:0]       local_time;
    logic [31:0]       heard_time;
    logic [31:0]       node_id;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    entry_t     entry;
    logic [6:0] count;
    logic [5:0] index;
  } res_t;

endpackage

### rtl/nht_ram.sv
`timescale 1ns / 1ps
// nht_ram: generic single-write, single-read memory with registered read data
// no dependencies
module nht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/nht_merge.sv
`timescale 1ns / 1ps
// nht_merge: builds the new table entry from a request and the stored entry
// depends on nht_pkg
module nht_merge (
  input  nht_pkg::req_t   req,
  input  nht_pkg::entry_t old_entry,
  input  logic            is_insert,
  input  logic [31:0]     sane_min,
  output nht_pkg::entry_t new_entry
);
  import nht_pkg::*;

  entry_t      base;
  logic [31:0] eff_time;
  logic [2:0]  hop_diff;
  logic        hops_ok;

  always_comb begin
    // a freshly inserted packet entry starts out blank
    base     = is_insert ? '0 : old_entry;
    eff_time = req.heard_time;
    if (req.heard_time == 32'd0 && req.local_time > sane_min) begin
      eff_time = req.local_time;
    end
    hop_diff = req.hop_init - req.hop_left;
    hops_ok  = (req.hop_init != 3'd0) && (req.hop_init >= req.hop_left);

    if (req.req_type == REQ_SYNC) begin
      new_entry.seen_time  = req.heard_time;
      new_entry.snr_q      = req.snr_q;
      new_entry.hops       = req.hop_dist;
      new_entry.hops_valid = req.has_hops;
      new_entry.relay      = req.via_relay;
    end else begin
      new_entry            = base;
      new_entry.relay      = req.via_relay;
      if (eff_time > base.seen_time) begin
        new_entry.seen_time = eff_time;
      end
      if (req.snr_q != 11'sd0) begin
        new_entry.snr_q = req.snr_q;
      end
      if (hops_ok) begin
        new_entry.hops       = {5'd0, hop_diff};
        new_entry.hops_valid = 1'b1;
      end
    end
  end

endmodule

### rtl/neighbor_heard_table.sv
`timescale 1ns / 1ps
// neighbor_heard_table: top level, request sequencer around the id and entry memories
// depends on nht_pkg, nht_ram, nht_merge
//
// Usage:
//   in_*  : one request per transaction; in_tuser holds the request kind
//           (sync record, heard packet, clear), in_tdata the record fields.
//   out_* : exactly one result per request, in request order; out_tuser holds
//           the status, out_tdata the touched slot, entry count and entry.
//   cfg_* : register writes (own id, own id valid, clock sanity minimum),
//           which the user makes only while idle; the block does not enforce it.
// Flow: clear and filtered requests go from idle straight to the result state.
//   Sync records and heard packets scan the id memory one entry per cycle
//   through its single read port; a match goes on to the read and modify
//   states, a miss to the modify state (insert) or, on a full table, to result.
//   One request is worked on at a time; the next one is taken as soon as the
//   result sits in the output register, even while the receiver stalls it.
// Reset: the table is empty and the control and config registers are reset;
//   memory contents are not cleared, only slots below the entry count are read.
// A stalled result holds the sequencer in its result state until taken.
module neighbor_heard_table #(
  parameter int MAX_ENTRIES = nht_pkg::MAX_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // node_id[31:0], heard_time[63:32], local_time[95:64], snr_q[106:96],
  // via_relay[107], has_hops[108], hop_dist[116:109], hop_init[119:117],
  // hop_left[122:120], zero fill[127:123]
  input  logic [127:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_index[5:0], entry_count[12:6], entry_seen_time[44:13],
  // entry_snr_q[55:45], entry_hops[63:56], entry_hops_valid[64],
  // entry_via_relay[65], zero fill[71:66]
  output logic [71:0]  out_tdata,
  // status[2:0]
  output logic [2:0]   out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  import nht_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  req_t          req_r, req_nxt;
  req_t          in_req;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic          insert_r, insert_nxt;
  res_t          res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_r, out_nxt;

  logic [31:0]   own_id_r;
  logic          own_valid_r;
  logic [31:0]   sane_min_r;

  logic          in_fire;
  logic          out_free;
  logic          filtered;
  logic          id_rd_en;
  logic [31:0]   id_rd_data;
  logic          id_we;
  logic          ent_we;
  logic [ENTRY_W-1:0] ent_rd_data;
  entry_t        old_entry;
  entry_t        new_entry;
  logic [CW-1:0] used_inc;
  logic [CW+6:0] used_w;
  logic [CW+6:0] inc_w;
  logic [AW+5:0] slot_w;
  logic [CW:0]   used_ext;

  assign in_req    = {in_tuser, in_tdata[$bits(req_t)-3:0]};
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign used_inc = used_r + CW'(1);
  assign used_w   = {7'd0, used_r};
  assign inc_w    = {7'd0, used_inc};
  assign slot_w   = {6'd0, slot_r};
  assign used_ext = {1'b0, used_r};

  assign filtered = (in_req.req_type == REQ_RSVD) ||
                    ((in_req.req_type == REQ_HEARD) &&
                     ((in_req.node_id == 32'd0) || (in_req.node_id == BROADCAST_ID) ||
                      (own_valid_r && in_req.node_id == own_id_r)));

  assign id_rd_en  = (state_r == S_SCAN) && (issue_r < used_r);
  assign id_we     = (state_r == S_MOD) && insert_r;
  assign ent_we    = (state_r == S_MOD);
  assign old_entry = entry_t'(ent_rd_data);

  nht_ram #(
    .WIDTH (32),
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_id_ram (
    .clk     (clk),
    .wr_en   (id_we),
    .wr_addr (slot_r),
    .wr_data (req_r.node_id),
    .rd_en   (id_rd_en),
    .rd_addr (issue_r[AW-1:0]),
    .rd_data (id_rd_data)
  );

  nht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ent_we),
    .wr_addr (slot_r),
    .wr_data (new_entry),
    .rd_en   (state_r == S_RD),
    .rd_addr (slot_r),
    .rd_data (ent_rd_data)
  );

  nht_merge u_merge (
    .req       (req_r),
    .old_entry (old_entry),
    .is_insert (insert_r),
    .sane_min  (sane_min_r),
    .new_entry (new_entry)
  );

  // accesses never overlap: the write of one request lands before the
  // sequencer returns to idle, so the next scan reads committed data
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    used_nxt      = used_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    slot_nxt      = slot_r;
    insert_nxt    = insert_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt   = in_req;
          res_nxt   = '0;
          issue_nxt = '0;
          pend_nxt  = 1'b0;
          if (in_req.req_type == REQ_CLEAR) begin
            used_nxt       = '0;
            res_nxt.status = ST_CLEARED;
            state_nxt      = S_RES;
          end else if (filtered) begin
            res_nxt.status = ST_FILTERED;
            res_nxt.count  = used_w[6:0];
            state_nxt      = S_RES;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // one id read issued per cycle, compared in the cycle after
        pend_nxt     = id_rd_en;
        pend_idx_nxt = issue_r[AW-1:0];
        if (id_rd_en) begin
          issue_nxt = issue_r + CW'(1);
        end
        if (pend_r && id_rd_data == req_r.node_id) begin
          slot_nxt   = pend_idx_r;
          insert_nxt = 1'b0;
          state_nxt  = S_RD;
        end else if (!pend_r && !id_rd_en) begin
          if (used_ext >= (CW + 1)'(MAX_ENTRIES)) begin
            res_nxt        = '0;
            res_nxt.status = ST_FULL;
            res_nxt.count  = used_w[6:0];
            state_nxt      = S_RES;
          end else begin
            slot_nxt   = used_r[AW-1:0];
            insert_nxt = 1'b1;
            state_nxt  = S_MOD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        res_nxt.entry = new_entry;
        res_nxt.index = slot_w[5:0];
        if (insert_r) begin
          used_nxt       = used_inc;
          res_nxt.status = ST_INSERTED;
          res_nxt.count  = inc_w[6:0];
        end else begin
          res_nxt.status = ST_UPDATED;
          res_nxt.count  = used_w[6:0];
        end
        state_nxt = S_RES;
      end
      S_RES: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      insert_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      insert_r    <= insert_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    pend_idx_r <= pend_idx_nxt;
    slot_r     <= slot_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r    <= 32'd0;
      own_valid_r <= 1'b0;
      sane_min_r  <= CLOCK_SANE_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_OWN_ID:       own_id_r    <= cfg_wdata;
        CFG_OWN_ID_VALID: own_valid_r <= cfg_wdata[0];
        CFG_SANE_MIN:     sane_min_r  <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {6'd0, out_r.entry, out_r.count, out_r.index};

  // an insert grows the table by exactly one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) && insert_r |=> used_r == $past(used_r) + CW'(1))
    else $error("entry count did not grow by one on insert");

  // a pending compare always refers to a slot inside the table
  a_pend_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && pend_r |-> CW'(pend_idx_r) < used_r)
    else $error("scan compared a slot beyond the entry count");

  // one request at a time: after an accept the input side closes
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("request accepted while another is in progress");

endmodule

### sim/neighbor_heard_table_tb.sv
`timescale 1ns / 1ps
// neighbor_heard_table_tb: self-checking bench for the neighbor heard table
// depends on nht_pkg and the neighbor_heard_table rtl, nothing else
module neighbor_heard_table_tb;
  import nht_pkg::*;

  localparam int TBL_DEPTH    = MAX_ENTRIES_DEF;
  localparam int POOL_N       = 72;
  localparam int LIMIT_CYCLES = 1000000;

  // mirror of the table, predicts one result per accepted request
  class heard_table_board;
    logic [31:0] ids [TBL_DEPTH];
    entry_t      ents [TBL_DEPTH];
    int unsigned used;
    logic [31:0] own_id;
    logic        own_valid;
    logic [31:0] sane_min;
    res_t        want_q[$];
    int unsigned errors;

    function new();
      used      = 0;
      own_id    = '0;
      own_valid = 1'b0;
      sane_min  = CLOCK_SANE_MIN_RST;
      errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_OWN_ID:       own_id = val;
        CFG_OWN_ID_VALID: own_valid = val[0];
        CFG_SANE_MIN:     sane_min = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return want_q.size();
    endfunction

    function void note_request(req_t r);
      res_t        w;
      int unsigned slot;
      int unsigned i;
      logic [31:0] t;
      w = '0;
      if (r.req_type == REQ_CLEAR) begin
        used = 0;
        w.status = ST_CLEARED;
      end else if (r.req_type == REQ_RSVD ||
                   (r.req_type == REQ_HEARD &&
                    (r.node_id == '0 || r.node_id == BROADCAST_ID ||
                     (own_valid && r.node_id == own_id)))) begin
        // sync records are never filtered
        w.status = ST_FILTERED;
      end else begin
        slot = used;
        for (i = 0; i < used; i++)
          if (slot == used && ids[i] == r.node_id) slot = i;
        if (slot == used && used >= TBL_DEPTH) begin
          w.status = ST_FULL;
        end else begin
          w.status = ST_UPDATED;
          if (slot == used) begin
            used++;
            w.status = ST_INSERTED;
            ids[slot] = r.node_id;
            ents[slot] = '0;
          end
          if (r.req_type == REQ_SYNC) begin
            ents[slot].seen_time  = r.heard_time;
            ents[slot].snr_q      = r.snr_q;
            ents[slot].relay      = r.via_relay;
            ents[slot].hops_valid = r.has_hops;
            ents[slot].hops       = r.hop_dist;
          end else begin
            t = r.heard_time;
            if (t == '0 && r.local_time > sane_min) t = r.local_time;
            if (t > ents[slot].seen_time) ents[slot].seen_time = t;
            if (r.snr_q != '0) ents[slot].snr_q = r.snr_q;
            if (r.hop_init != '0 && r.hop_init >= r.hop_left) begin
              ents[slot].hops_valid = 1'b1;
              ents[slot].hops       = {5'b0, 3'(r.hop_init - r.hop_left)};
            end
            ents[slot].relay = r.via_relay;
          end
          w.index = slot[5:0];
          w.entry = ents[slot];
        end
      end
      w.count = used[6:0];
      want_q.push_back(w);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void check_result(logic [2:0] st, logic [71:0] d);
      res_t want;
      res_t got;
      got.status = st;
      got.index  = d[5:0];
      got.count  = d[12:6];
      got.entry  = d[65:13];
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with nothing pending: status %h data %h", st, d);
        return;
      end
      want = want_q.pop_front();
      field_check("status", 32'(want.status), 32'(got.status));
      field_check("entry_index", 32'(want.index), 32'(got.index));
      field_check("entry_count", 32'(want.count), 32'(got.count));
      field_check("entry_seen_time", want.entry.seen_time, got.entry.seen_time);
      field_check("entry_snr_q", 32'(want.entry.snr_q), 32'(got.entry.snr_q));
      field_check("entry_hops", 32'(want.entry.hops), 32'(got.entry.hops));
      field_check("entry_hops_valid", 32'(want.entry.hops_valid),
                  32'(got.entry.hops_valid));
      field_check("entry_via_relay", 32'(want.entry.relay), 32'(got.entry.relay));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic [127:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         in_tvalid;
  logic         in_tready;
  logic [71:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [31:0]  cfg_wdata;

  heard_table_board board;
  logic [31:0]      id_pool [POOL_N];
  int unsigned      sent_cnt = 0;
  int unsigned      cycles = 0;

  neighbor_heard_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("** neighbor_heard_table: FAILED **");
      $finish;
    end
  end

  // entered and left at a falling edge; valid stays high into a zero gap
  task automatic send_req(input req_t r);
    int unsigned gap;
    gap = (sent_cnt % 200 >= 160) ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {5'b0, r.hop_left, r.hop_init, r.hop_dist, r.has_hops, r.via_relay,
                  r.snr_q, r.local_time, r.heard_time, r.node_id};
    in_tuser  <= r.req_type;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(r);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic post_request(input logic [1:0] kind, input logic [31:0] id,
                              input logic [31:0] htime, input logic [31:0] ltime,
                              input logic signed [10:0] snr, input logic relay,
                              input logic hops_ok, input logic [7:0] hops,
                              input logic [2:0] hstart, input logic [2:0] hlimit);
    req_t r;
    r.req_type   = kind;
    r.node_id    = id;
    r.heard_time = htime;
    r.local_time = ltime;
    r.snr_q      = snr;
    r.via_relay  = relay;
    r.has_hops   = hops_ok;
    r.hop_dist   = hops;
    r.hop_init   = hstart;
    r.hop_left   = hlimit;
    send_req(r);
  endtask

  function automatic req_t random_request(logic [1:0] kind, logic [31:0] id);
    req_t r;
    r.req_type = kind;
    r.node_id  = id;
    case ($urandom_range(0, 3))
      0:       r.heard_time = '0;
      1:       r.heard_time = $urandom_range(0, 255);
      2:       r.heard_time = board.sane_min + $urandom_range(0, 2) - 1;
      default: r.heard_time = $urandom();
    endcase
    // local time straddles the sanity threshold half the time
    if ($urandom_range(0, 1) == 0) r.local_time = board.sane_min + $urandom_range(0, 2) - 1;
    else r.local_time = $urandom();
    r.snr_q     = ($urandom_range(0, 3) == 0) ? 11'sd0 : 11'($urandom());
    r.via_relay = 1'($urandom_range(0, 1));
    r.has_hops  = 1'($urandom_range(0, 1));
    r.hop_dist  = 8'($urandom_range(0, 255));
    r.hop_init  = 3'($urandom_range(0, 7));
    r.hop_left  = 3'($urandom_range(0, 7));
    return r;
  endfunction

  // table must be idle before a register write
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // result side: random stalls, idle-free stretches and two long hold-offs
  initial begin
    int unsigned stall;
    int unsigned taken;
    out_tready = 1'b0;
    taken = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (taken == 300 || taken == 1100) stall = 500;
      else if (taken % 150 >= 110) stall = 0;
      else stall = $urandom_range(0, 18);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      board.check_result(out_tuser, out_tdata);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    logic [31:0] own;
    logic        own_ok;
    logic [31:0] sane;
    logic [31:0] id;
    logic [1:0]  kind;
    int unsigned pick;
    int          p;
    int          k;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_SYNC;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_OWN_ID;
    cfg_wdata = '0;
    board = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cfg_write(CFG_OWN_ID, 32'h1234_5678);
    cfg_write(CFG_OWN_ID_VALID, 32'd1);

    // sync records with reserved-looking ids still go in
    post_request(REQ_SYNC, 32'h0, 32'hFFFF_FFFF, 32'h0, -11'sd1024, 1, 1, 8'hFF, 0, 0);
    post_request(REQ_SYNC, BROADCAST_ID, 32'h0, 32'hFFFF_FFFF, 11'sd1023, 0, 0, 8'h00, 7, 0);
    post_request(REQ_SYNC, 32'h1234_5678, 32'd1, 32'h0, 11'sd0, 1, 1, 8'h01, 0, 0);
    // packets from zero, broadcast, own id and the unused kind are filtered
    post_request(REQ_HEARD, 32'h0, 32'd5, 32'h0, 11'sd1, 1, 0, 8'h00, 3, 1);
    post_request(REQ_HEARD, BROADCAST_ID, 32'd5, 32'h0, 11'sd1, 1, 0, 8'h00, 3, 1);
    post_request(REQ_HEARD, 32'h1234_5678, 32'd5, 32'h0, 11'sd1, 1, 0, 8'h00, 3, 1);
    post_request(REQ_RSVD, 32'hA5A5_5A5A, 32'd5, 32'h0, 11'sd1, 1, 0, 8'h00, 3, 1);
    // missing time falls back to local time only above the threshold
    post_request(REQ_HEARD, 32'hA5A5_5A5A, 32'h0, CLOCK_SANE_MIN_RST + 1, 11'sd0, 1, 0,
                 8'h00, 0, 0);
    post_request(REQ_HEARD, 32'hA5A5_5A5A, 32'h0, CLOCK_SANE_MIN_RST, 11'sd5, 0, 1,
                 8'h33, 3, 5);
    // older time ignored, zero snr keeps old value, equal start and limit gives 0 hops
    post_request(REQ_HEARD, 32'hA5A5_5A5A, 32'd100, 32'hFFFF_FFFF, 11'sd0, 1, 0, 8'h00, 7, 7);
    post_request(REQ_HEARD, 32'hA5A5_5A5A, 32'hFFFF_FFFF, 32'h0, -11'sd1, 0, 0, 8'h00, 7, 0);
    post_request(REQ_SYNC, 32'hA5A5_5A5A, 32'd5, 32'h0, 11'sd0, 0, 0, 8'hAA, 7, 7);
    post_request(REQ_HEARD, 32'h1, 32'd1, 32'h0, 11'sh2AA, 1, 0, 8'h00, 1, 1);
    post_request(REQ_HEARD, 32'hFFFF_FFFE, 32'h0, 32'h0, 11'sh555, 0, 0, 8'h00, 6, 2);
    post_request(REQ_CLEAR, 32'hA5A5_5A5A, 32'h0, 32'h0, 11'sd0, 0, 0, 8'h00, 0, 0);
    post_request(REQ_HEARD, 32'h1234_5678, 32'd9, 32'h0, 11'sd3, 0, 0, 8'h00, 2, 1);
    post_request(REQ_HEARD, 32'hA5A5_5A5A, 32'd7, 32'h0, 11'sd3, 1, 0, 8'h00, 2, 1);
    post_request(REQ_SYNC, 32'h0, 32'd8, 32'h0, 11'sd2, 0, 1, 8'h10, 0, 0);

    for (p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: begin own = $urandom(); own_ok = 1'b1; sane = CLOCK_SANE_MIN_RST; end
        1: begin own = 32'h0; own_ok = 1'b0; sane = 32'h0; end
        2: begin own = 32'hFFFF_FFFF; own_ok = 1'b1; sane = 32'hFFFF_FFFF; end
        default: begin own = $urandom(); own_ok = 1'b1; sane = $urandom(); end
      endcase
      cfg_write(CFG_OWN_ID, own);
      cfg_write(CFG_OWN_ID_VALID, {31'b0, own_ok});
      cfg_write(CFG_SANE_MIN, sane);

      for (k = 0; k < POOL_N; k++) id_pool[k] = $urandom();
      id_pool[0] = 32'h0;
      id_pool[1] = BROADCAST_ID;
      id_pool[2] = own;

      // start empty, then fill past capacity so the last few get dropped
      post_request(REQ_CLEAR, 32'h0, 32'h0, 32'h0, 11'sd0, 0, 0, 8'h00, 0, 0);
      for (k = 0; k < 70; k++) send_req(random_request(REQ_SYNC, id_pool[k]));

      for (k = 0; k < 370; k++) begin
        pick = $urandom_range(0, 999);
        if (pick < 4) kind = REQ_CLEAR;
        else if (pick < 14) kind = REQ_RSVD;
        else if (pick < 420) kind = REQ_SYNC;
        else kind = REQ_HEARD;
        if ($urandom_range(0, 19) == 0) id = $urandom();
        else id = id_pool[$urandom_range(0, POOL_N - 1)];
        send_req(random_request(kind, id));
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("** neighbor_heard_table: PASSED **");
    else
      $display("** neighbor_heard_table: FAILED **");
    $finish;
  end

endmodule

### filelist.f
rtl/nht_pkg.sv
rtl/nht_ram.sv
rtl/nht_merge.sv
rtl/neighbor_heard_table.sv
sim/neighbor_heard_table_tb.sv
